[rtl/core/adi_pkg.sv]
package adi_pkg;

  // field widths
  localparam int unsigned RAW_W      = 16;
  localparam int unsigned CONV_W     = 24;
  localparam int unsigned BIAS_W     = 32;
  localparam int unsigned ACC_W      = 25;
  localparam int unsigned POS_W      = 40;
  localparam int unsigned THR_W      = 10;
  localparam int unsigned DT_W       = 16;
  localparam int unsigned CAL_W      = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // bias-removed acceleration inside the datapath; the bias can reach a whole
  // calibration sum when the count is lowered mid calibration
  localparam int unsigned A_W = 30;

  // fraction bits of the dead-zone limits
  localparam int unsigned LIM_FRAC = 8;

  // multiplier digit width, bits of the multiplier consumed per cycle
  localparam int unsigned DIG_W = 4;

  // a * dt product and the scaled terms taken from the products
  localparam int unsigned PROD1_W = A_W + DT_W;
  localparam int unsigned V_SHIFT = 32;
  localparam int unsigned P_SHIFT = 33;
  localparam int unsigned Q1_W    = 30;
  localparam int unsigned Q2_W    = 29;

  // longest calibration run
  localparam int unsigned MAX_CAL = 64;

  // 1/1024 g to cm/s2 with 8 fraction bits is x981 then /4
  localparam logic [9:0] G_SCALE = 10'd981;

  // register reset values
  localparam logic [THR_W-1:0] ACC_THR_RST  = 10'd5;
  localparam logic [THR_W-1:0] VEL_THR_RST  = 10'd22;
  localparam logic [DT_W-1:0]  DT_RST       = 16'd6554;
  localparam logic [DT_W-1:0]  BLEND_RST    = 16'd58982;
  localparam logic [CAL_W-1:0] CAL_CNT_RST  = 7'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACC_THR   = 3'd0,
    REG_VEL_THR   = 3'd1,
    REG_TIME_STEP = 3'd2,
    REG_BLEND     = 3'd3,
    REG_CAL_CNT   = 3'd4
  } cfg_idx_e;

  typedef logic signed [RAW_W-1:0] raw_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [POS_W-1:0] pos_t;

endpackage

[rtl/core/adi_in_if.sv]
interface adi_in_if;
  import adi_pkg::*;

  logic valid;
  logic ready;
  raw_t raw_accel_x;
  raw_t raw_accel_y;
  raw_t raw_accel_z;

  modport source (
    output valid,
    output raw_accel_x,
    output raw_accel_y,
    output raw_accel_z,
    input  ready
  );

  modport sink (
    input  valid,
    input  raw_accel_x,
    input  raw_accel_y,
    input  raw_accel_z,
    output ready
  );
endinterface

[rtl/core/adi_out_if.sv]
interface adi_out_if;
  import adi_pkg::*;

  logic valid;
  logic ready;
  acc_t filtered_accel_x;
  acc_t filtered_accel_y;
  acc_t filtered_accel_z;
  pos_t position_x;
  pos_t position_y;
  pos_t position_z;

  modport source (
    output valid,
    output filtered_accel_x,
    output filtered_accel_y,
    output filtered_accel_z,
    output position_x,
    output position_y,
    output position_z,
    input  ready
  );

  modport sink (
    input  valid,
    input  filtered_accel_x,
    input  filtered_accel_y,
    input  filtered_accel_z,
    input  position_x,
    input  position_y,
    input  position_z,
    output ready
  );
endinterface

[rtl/core/adi_mul.sv]
module adi_mul #(
  parameter int unsigned X_W = 41
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [X_W-1:0]                x_i,
  input  logic        [adi_pkg::DT_W-1:0]      m_i,
  output logic                                 done_o,
  output logic signed [X_W+adi_pkg::DT_W-1:0]  prod_o
);
  import adi_pkg::*;

  localparam int unsigned STEPS = DT_W / DIG_W;
  localparam int unsigned CNT_W = $clog2(STEPS);
  localparam int unsigned SUM_W = X_W + DIG_W;

  logic                    busy_q;
  logic                    done_q;
  logic [CNT_W-1:0]        cnt_q;
  logic signed [X_W-1:0]   x_q;
  logic signed [X_W-1:0]   p_q;
  logic [DT_W-1:0]         lo_q;
  logic [DT_W-1:0]         m_q;
  logic signed [SUM_W-1:0] pp;
  logic signed [SUM_W-1:0] sum;

  // one multiplier digit per cycle, lsb first
  assign pp  = SUM_W'(x_q) * SUM_W'($signed({1'b0, m_q[DIG_W-1:0]}));
  assign sum = SUM_W'(p_q) + pp;

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(STEPS - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // partial product shifts right, low digits drop into lo_q
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q  <= x_i;
      m_q  <= m_i;
      p_q  <= '0;
      lo_q <= '0;
    end else if (busy_q) begin
      p_q  <= sum[SUM_W-1:DIG_W];
      lo_q <= {sum[DIG_W-1:0], lo_q[DT_W-1:DIG_W]};
      m_q  <= m_q >> DIG_W;
    end
  end

  assign done_o = done_q;
  assign prod_o = $signed({p_q, lo_q});

endmodule

[rtl/core/adi_div.sv]
module adi_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [adi_pkg::BIAS_W-1:0]  dividend_i,
  input  logic        [adi_pkg::CAL_W-1:0]   divisor_i,
  output logic                               done_o,
  output logic signed [adi_pkg::BIAS_W-1:0]  quotient_o
);
  import adi_pkg::*;

  localparam int unsigned CNT_W = $clog2(BIAS_W);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [BIAS_W-1:0] dq_q;
  logic [CAL_W-1:0]  rem_q;
  logic [CAL_W-1:0]  d_q;
  logic              neg_q;
  logic [BIAS_W-1:0] mag;
  logic [CAL_W:0]    trial;
  logic [CAL_W:0]    diff;
  logic              fits;

  // magnitude of the dividend, sign restored at the end
  assign mag = dividend_i[BIAS_W-1] ? (~dividend_i + BIAS_W'(1)) : dividend_i;

  // restoring step, one quotient bit per cycle
  assign trial = {rem_q, dq_q[BIAS_W-1]};
  assign diff  = trial - {1'b0, d_q};
  assign fits  = (trial >= {1'b0, d_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(BIAS_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= mag;
      rem_q <= '0;
      d_q   <= divisor_i;
      neg_q <= dividend_i[BIAS_W-1];
    end else if (busy_q) begin
      rem_q <= fits ? diff[CAL_W-1:0] : trial[CAL_W-1:0];
      dq_q  <= {dq_q[BIAS_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = $signed(neg_q ? (~dq_q + BIAS_W'(1)) : dq_q);

endmodule

[rtl/core/accel_dead_reckoning_integrator_unit.sv]
// Three-axis accelerometer dead reckoning.
// in_i carries one word of raw x/y/z samples in 1/1024 g; out_o carries one
// word of filtered acceleration (cm/s2, 8 fraction bits) and position
// (cm, 8 fraction bits) per running sample. Both use valid/ready and move a
// word at a clock edge where both are high. Registers must be written by the
// user through cfg_we_i/cfg_idx_i/cfg_wdata_i only while the block is idle;
// the block itself does not enforce this. The first N samples only build the
// bias sums, with no result. Sample N+1 divides the sums into the bias, one
// quotient bit per cycle per axis, with no result. Each later sample is
// handled axis by axis: bias removal, then four products on one shared
// multiplier that consumes a 4-bit digit of dt or w per cycle, then a
// saturating position update; after the last axis the result is loaded
// into the output register. The next sample is taken once the previous
// result is in the output register, so the block takes no new sample while
// one is in progress. If out_o stalls, the following sample is still
// computed and the block holds it in its last step, with in_i.ready low,
// until the output register frees up. Reset restores the register defaults
// and clears the sample count, bias sums, velocity and position; no word is
// pending after reset.
module accel_dead_reckoning_integrator_unit #(
  parameter int unsigned STATE_WIDTH = 40
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [adi_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [adi_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  adi_in_if.sink                            in_i,
  adi_out_if.source                         out_o
);
  import adi_pkg::*;

  localparam int unsigned SW      = STATE_WIDTH;
  localparam int unsigned XW      = (SW > PROD1_W) ? SW : PROD1_W;
  localparam int unsigned PW      = XW + DT_W;
  localparam int unsigned EW      = (SW > POS_W) ? SW : POS_W;
  localparam int unsigned CONVP_W = RAW_W + 11;
  localparam int unsigned AXES    = 3;
  localparam logic [1:0]  LAST_AXIS = 2'd2;

  typedef enum logic [11:0] {
    S_IDLE  = 12'h001,
    S_ACCUM = 12'h002,
    S_DIV   = 12'h004,
    S_DIVW  = 12'h008,
    S_ACC_A = 12'h010,
    S_MUL1  = 12'h020,
    S_MUL2  = 12'h040,
    S_MUL3  = 12'h080,
    S_MUL4  = 12'h100,
    S_POS1  = 12'h200,
    S_POS2  = 12'h400,
    S_DONE  = 12'h800
  } state_e;

  state_e state_q, state_d;
  logic [1:0] axis_q;

  logic [THR_W-1:0] acc_thr_q;
  logic [THR_W-1:0] vel_thr_q;
  logic [DT_W-1:0]  dt_q;
  logic [DT_W-1:0]  w_q;
  logic [CAL_W-1:0] cal_q;

  logic [CAL_W-1:0]        count_q;
  logic                    cal_done_q;
  logic signed [BIAS_W-1:0] bias_q [AXES];
  logic signed [SW-1:0]    vel_q [AXES];
  logic signed [SW-1:0]    pos_q [AXES];

  raw_t                     raw_q [AXES];
  logic signed [A_W-1:0]    a_q;
  acc_t                     res_a_q [AXES];
  logic signed [PROD1_W-1:0] prod1_q;
  logic signed [Q1_W-1:0]   q1_q;
  logic signed [Q2_W-1:0]   q2_q;
  logic signed [SW-1:0]     t1_q;
  logic signed [SW-1:0]     vs_q;
  logic signed [SW-1:0]     vn_q;

  logic out_valid_q;
  acc_t out_acc_q [AXES];
  pos_t out_pos_q [AXES];

  logic in_fire;
  logic out_free;
  logic [CAL_W-1:0] n_one;
  logic [CAL_W-1:0] n_eff;
  logic signed [CONVP_W-1:0] conv_full;
  logic signed [CONV_W-1:0]  conv_cur;
  logic signed [A_W-1:0]     a_cur;

  logic                  mul_start;
  logic signed [XW-1:0]  mul_x;
  logic [DT_W-1:0]       mul_m;
  logic                  mul_done;
  logic signed [PW-1:0]  mul_prod;

  logic                     div_done;
  logic signed [BIAS_W-1:0] div_quot;

  logic signed [SW-1:0] add_a;
  logic signed [SW-1:0] add_b;
  logic signed [SW:0]   add_sum;
  logic signed [SW-1:0] add_sat;

  // clamp a one-bit-grown sum back to the state range
  function automatic logic signed [SW-1:0] sat_sw(input logic signed [SW:0] x);
    logic signed [SW-1:0] r;
    if (x[SW] != x[SW-1]) begin
      r = x[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      r = x[SW-1:0];
    end
    return r;
  endfunction

  // zero a velocity whose magnitude is under the limit
  function automatic logic signed [SW-1:0] dz_vel(input logic signed [SW-1:0] x,
                                                  input logic [THR_W-1:0] thr);
    logic signed [SW:0] xe;
    logic signed [SW:0] le;
    xe = (SW+1)'(x);
    le = (SW+1)'($signed({1'b0, thr, {LIM_FRAC{1'b0}}}));
    return ((xe < le) && (xe > -le)) ? '0 : x;
  endfunction

  // zero an acceleration whose magnitude is under the limit
  function automatic logic signed [A_W-1:0] dz_acc(input logic signed [A_W-1:0] x,
                                                   input logic [THR_W-1:0] thr);
    logic signed [A_W:0] xe;
    logic signed [A_W:0] le;
    xe = (A_W+1)'(x);
    le = (A_W+1)'($signed({1'b0, thr, {LIM_FRAC{1'b0}}}));
    return ((xe < le) && (xe > -le)) ? '0 : x;
  endfunction

  // emitted position is limited to the output field
  function automatic pos_t clamp_out(input logic signed [SW-1:0] p);
    logic signed [EW-1:0] pe;
    logic signed [EW-1:0] pmax;
    logic signed [EW-1:0] pmin;
    pe   = EW'(p);
    pmax = {{(EW-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
    pmin = ~pmax;
    if (pe > pmax) begin
      return pmax[POS_W-1:0];
    end else if (pe < pmin) begin
      return pmin[POS_W-1:0];
    end
    return pe[POS_W-1:0];
  endfunction

  // handshakes
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == S_IDLE);

  // effective calibration length
  assign n_one = (cal_q == '0) ? CAL_W'(1) : cal_q;
  assign n_eff = (n_one > CAL_W'(MAX_CAL)) ? CAL_W'(MAX_CAL) : n_one;

  // unit conversion and bias removal for the current axis
  assign conv_full = CONVP_W'(raw_q[axis_q]) * CONVP_W'($signed({1'b0, G_SCALE}));
  assign conv_cur  = conv_full[CONV_W+1:2];
  assign a_cur     = dz_acc(A_W'(conv_cur) - A_W'(bias_q[axis_q]), acc_thr_q);

  // shared saturating adder
  always_comb begin
    add_a = pos_q[axis_q];
    add_b = SW'(q2_q);
    case (state_q)
      S_MUL3: begin
        add_a = vel_q[axis_q];
        add_b = SW'(q1_q);
      end
      S_POS1: begin
        add_b = t1_q;
      end
      default: begin
      end
    endcase
  end

  assign add_sum = (SW+1)'(add_a) + (SW+1)'(add_b);
  assign add_sat = sat_sw(add_sum);

  // multiplier operand select
  always_comb begin
    mul_start = 1'b0;
    mul_x     = '0;
    mul_m     = dt_q;
    case (state_q)
      S_ACC_A: begin
        mul_start = 1'b1;
        mul_x     = XW'(a_cur);
      end
      S_MUL1: begin
        mul_start = mul_done;
        mul_x     = XW'($signed(mul_prod[PROD1_W-1:0]));
        mul_m     = w_q;
      end
      S_MUL2: begin
        mul_start = mul_done;
        mul_x     = XW'(prod1_q);
      end
      S_MUL3: begin
        mul_start = mul_done;
        mul_x     = XW'(vel_q[axis_q]);
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (cal_done_q) begin
            state_d = S_ACC_A;
          end else if (count_q < n_eff) begin
            state_d = S_ACCUM;
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_ACCUM: begin
        if (axis_q == LAST_AXIS) state_d = S_IDLE;
      end
      S_DIV:   state_d = S_DIVW;
      S_DIVW: begin
        if (div_done) state_d = (axis_q == LAST_AXIS) ? S_IDLE : S_DIV;
      end
      S_ACC_A: state_d = S_MUL1;
      S_MUL1: begin
        if (mul_done) state_d = S_MUL2;
      end
      S_MUL2: begin
        if (mul_done) state_d = S_MUL3;
      end
      S_MUL3: begin
        if (mul_done) state_d = S_MUL4;
      end
      S_MUL4: begin
        if (mul_done) state_d = S_POS1;
      end
      S_POS1:  state_d = S_POS2;
      S_POS2:  state_d = (axis_q == LAST_AXIS) ? S_DONE : S_ACC_A;
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control, registers and integrator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= '0;
      acc_thr_q   <= ACC_THR_RST;
      vel_thr_q   <= VEL_THR_RST;
      dt_q        <= DT_RST;
      w_q         <= BLEND_RST;
      cal_q       <= CAL_CNT_RST;
      count_q     <= '0;
      cal_done_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        bias_q[i] <= '0;
        vel_q[i]  <= '0;
        pos_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;

      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ACC_THR:   acc_thr_q <= cfg_wdata_i[THR_W-1:0];
          REG_VEL_THR:   vel_thr_q <= cfg_wdata_i[THR_W-1:0];
          REG_TIME_STEP: dt_q      <= cfg_wdata_i[DT_W-1:0];
          REG_BLEND:     w_q       <= cfg_wdata_i[DT_W-1:0];
          REG_CAL_CNT:   cal_q     <= cfg_wdata_i[CAL_W-1:0];
          default: begin
          end
        endcase
      end

      case (state_q)
        S_ACCUM: begin
          bias_q[axis_q] <= bias_q[axis_q] + BIAS_W'(conv_cur);
          if (axis_q == LAST_AXIS) begin
            axis_q  <= '0;
            count_q <= count_q + CAL_W'(1);
          end else begin
            axis_q <= axis_q + 2'd1;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            bias_q[axis_q] <= div_quot;
            if (axis_q == LAST_AXIS) begin
              axis_q     <= '0;
              cal_done_q <= 1'b1;
            end else begin
              axis_q <= axis_q + 2'd1;
            end
          end
        end
        S_POS1: begin
          pos_q[axis_q] <= add_sat;
        end
        S_POS2: begin
          pos_q[axis_q] <= add_sat;
          vel_q[axis_q] <= vn_q;
          axis_q        <= (axis_q == LAST_AXIS) ? 2'd0 : axis_q + 2'd1;
        end
        default: begin
        end
      endcase

      // output word valid
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          raw_q[0] <= in_i.raw_accel_x;
          raw_q[1] <= in_i.raw_accel_y;
          raw_q[2] <= in_i.raw_accel_z;
        end
      end
      S_ACC_A: begin
        a_q <= a_cur;
      end
      S_MUL1: begin
        if (mul_done) prod1_q <= mul_prod[PROD1_W-1:0];
      end
      S_MUL2: begin
        if (mul_done) q1_q <= mul_prod[V_SHIFT +: Q1_W];
      end
      S_MUL3: begin
        // velocity update runs while a*dt*dt is formed
        vs_q <= add_sat;
        vn_q <= dz_vel(vs_q, vel_thr_q);
        if (mul_done) q2_q <= mul_prod[P_SHIFT +: Q2_W];
      end
      S_MUL4: begin
        if (mul_done) t1_q <= mul_prod[DT_W +: SW];
      end
      S_POS2: begin
        res_a_q[axis_q] <= a_q[ACC_W-1:0];
      end
      S_DONE: begin
        if (out_free) begin
          for (int i = 0; i < AXES; i++) begin
            out_acc_q[i] <= res_a_q[i];
            out_pos_q[i] <= clamp_out(pos_q[i]);
          end
        end
      end
      default: begin
      end
    endcase
  end

  adi_mul #(
    .X_W (XW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .x_i     (mul_x),
    .m_i     (mul_m),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  adi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_DIV),
    .dividend_i (bias_q[axis_q]),
    .divisor_i  (n_eff),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // output channel
  assign out_o.valid            = out_valid_q;
  assign out_o.filtered_accel_x = out_acc_q[0];
  assign out_o.filtered_accel_y = out_acc_q[1];
  assign out_o.filtered_accel_z = out_acc_q[2];
  assign out_o.position_x       = out_pos_q[0];
  assign out_o.position_y       = out_pos_q[1];
  assign out_o.position_z       = out_pos_q[2];

endmodule
